FILE: hw/rtl/ckey_pkg.sv
// shared constants and operation codes for the charset key enumerator
// no dependencies; used by every module of the block
`default_nettype none

package ckey_pkg;

    // default sizing
    localparam int MAX_KEY_LEN_DEF    = 14;
    localparam int CHARSET_DEPTH_DEF  = 256;
    localparam int POSITION_WIDTH_DEF = 64;

    // fixed field widths
    localparam int OP_W       = 2;
    localparam int CHAR_W     = 8;
    localparam int SIZE_W     = 9;
    localparam int CHARPOS_W  = 4;
    localparam int M_DATA_W   = 16;

    localparam logic [SIZE_W-1:0] CHARSET_SIZE_RST = 9'd26;
    localparam logic [SIZE_W-1:0] CHARSET_SIZE_MIN = 9'd2;

    // operation codes carried in s_tuser
    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_SEED    = 2'd1;
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;

endpackage

`default_nettype wire

FILE: hw/rtl/ckey_ram.sv
// generic single-write, single-read ram with registered read data
// depends on ckey_pkg for default sizing
`default_nettype none

module ckey_ram #(
    parameter int WIDTH = ckey_pkg::CHAR_W,
    parameter int DEPTH = ckey_pkg::CHARSET_DEPTH_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ckey_div.sv
// restoring divider, one quotient bit per cycle, divisor up to 256
// depends on ckey_pkg for widths
`default_nettype none

module ckey_div #(
    parameter int POSITION_WIDTH = ckey_pkg::POSITION_WIDTH_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [POSITION_WIDTH-1:0]     dividend,
    input  wire logic [ckey_pkg::SIZE_W-1:0]   divisor,
    output logic                               done,
    output logic      [POSITION_WIDTH-1:0]     quotient,
    output logic      [ckey_pkg::CHAR_W-1:0]   remainder
);
    import ckey_pkg::*;

    localparam int CNT_W = $clog2(POSITION_WIDTH + 1);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [POSITION_WIDTH-1:0] quot_reg, quot_next;
    logic [CHAR_W-1:0]         rem_reg, rem_next;
    logic [SIZE_W-1:0]         shifted;
    logic [SIZE_W-1:0]         diff;
    logic                      ge;

    always_comb begin
        shifted   = {rem_reg, quot_reg[POSITION_WIDTH-1]};
        ge        = (shifted >= divisor);
        diff      = shifted - divisor;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(POSITION_WIDTH);
            quot_next = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            quot_next = {quot_reg[POSITION_WIDTH-2:0], ge};
            rem_next  = ge ? diff[CHAR_W-1:0] : shifted[CHAR_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/charset_key_enumerator_unit.sv
// charset key enumerator: load / seed / advance with key emission, one char per transfer
// seed: one division in the shared divider per digit (up to MAX_KEY_LEN digits)
// advance: add one to the lowest digit, carrying past top-value digits; a carry out adds a zero digit
// emission: table read, then output register; one char per cycle while m_tready is high
// load: no results; s_tready is low from a seed or advance until its last char is registered
// reset (aresetn low, synchronous): size 26, key one digit of zero; charset table not cleared
`default_nettype none

module charset_key_enumerator_unit #(
    parameter int MAX_KEY_LEN    = ckey_pkg::MAX_KEY_LEN_DEF,
    parameter int CHARSET_DEPTH  = ckey_pkg::CHARSET_DEPTH_DEF,
    parameter int POSITION_WIDTH = ckey_pkg::POSITION_WIDTH_DEF,
    localparam int S_DATA_W = ((POSITION_WIDTH + 16 + 7) / 8) * 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration: charset_size
    input  wire logic                            cfg_we,
    input  wire logic [ckey_pkg::SIZE_W-1:0]     cfg_wdata,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // table_index [7:0], table_char [15:8], start_position above, zero pad
    input  wire logic [S_DATA_W-1:0]             s_tdata,
    // operation [1:0]
    input  wire logic [ckey_pkg::OP_W-1:0]       s_tuser,
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // key_char [7:0], char_position [11:8], zero pad [15:12]
    output logic      [ckey_pkg::M_DATA_W-1:0]   m_tdata,
    // last_char
    output logic                                 m_tlast,
    // length_overflow
    output logic                                 m_tuser
);
    import ckey_pkg::*;

    localparam int CNT_W  = $clog2(MAX_KEY_LEN + 1);
    localparam int IDX_W  = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
    localparam int ADDR_W = $clog2(CHARSET_DEPTH);

    // sequencer states
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_SEED_KICK = 3'd1;
    localparam logic [2:0] ST_SEED_WAIT = 3'd2;
    localparam logic [2:0] ST_ADV       = 3'd3;
    localparam logic [2:0] ST_ADV_GROW  = 3'd4;
    localparam logic [2:0] ST_EMIT      = 3'd5;

    // input field split
    logic [CHAR_W-1:0]         in_index;
    logic [CHAR_W-1:0]         in_char;
    logic [POSITION_WIDTH-1:0] in_pos;
    logic                      s_xfer;

    assign in_index = s_tdata[7:0];
    assign in_char  = s_tdata[15:8];
    assign in_pos   = s_tdata[16 +: POSITION_WIDTH];

    // configuration and clamped charset size
    logic [SIZE_W-1:0] size_reg;
    logic [SIZE_W-1:0] eff_size;
    logic [SIZE_W-1:0] last_digit;

    always_comb begin
        if (size_reg < CHARSET_SIZE_MIN) begin
            eff_size = CHARSET_SIZE_MIN;
        end else if (size_reg > SIZE_W'(CHARSET_DEPTH)) begin
            eff_size = SIZE_W'(CHARSET_DEPTH);
        end else begin
            eff_size = size_reg;
        end
        last_digit = eff_size - 1'b1;
    end

    // sequencer and key state
    logic [2:0]                state_reg, state_next;
    logic [CNT_W-1:0]          idx_reg, idx_next;
    logic [CNT_W-1:0]          len_reg, len_next;
    logic [POSITION_WIDTH-1:0] num_reg, num_next;
    logic                      ovf_reg, ovf_next;
    logic [CHAR_W-1:0]         key_digits_reg [MAX_KEY_LEN];
    logic                      dig_we;
    logic [CHAR_W-1:0]         dig_wdata;
    logic [CHAR_W-1:0]         cur_digit;
    logic [CNT_W:0]            idx_inc;

    // emission pipeline: ram read, then output register
    logic                      rd_issue;
    logic                      rd_pend_reg, rd_pend_next;
    logic [CNT_W-1:0]          pend_idx_reg, pend_idx_next;
    logic [CNT_W:0]            pend_inc;
    logic                      load_out;
    logic                      out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]         out_char_reg, out_char_next;
    logic [CHARPOS_W-1:0]      out_pos_reg, out_pos_next;
    logic                      out_last_reg, out_last_next;
    logic                      out_ovf_reg, out_ovf_next;
    logic [CNT_W+CHARPOS_W-1:0] pend_pos_ext;

    // charset table
    logic              ram_we;
    logic [CHAR_W-1:0] ram_rdata;

    // shared divider
    logic                      div_start;
    logic                      div_done;
    logic [POSITION_WIDTH-1:0] div_quot;
    logic [CHAR_W-1:0]         div_rem;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign cur_digit = key_digits_reg[idx_reg[IDX_W-1:0]];
    assign idx_inc   = {1'b0, idx_reg} + {{CNT_W{1'b0}}, 1'b1};

    ckey_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CHARSET_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (in_index[ADDR_W-1:0]),
        .wdata (in_char),
        .re    (rd_issue),
        .raddr (cur_digit[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    ckey_div #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (num_reg),
        .divisor   (eff_size),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    // output register handshake
    assign load_out = rd_pend_reg && (!out_valid_reg || m_tready);

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        len_next      = len_reg;
        num_next      = num_reg;
        ovf_next      = ovf_reg;
        dig_we        = 1'b0;
        dig_wdata     = '0;
        div_start     = 1'b0;
        rd_issue      = 1'b0;
        ram_we        = 1'b0;
        pend_idx_next = pend_idx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    unique case (s_tuser)
                        OP_LOAD: begin
                            // indexes beyond the table are dropped
                            ram_we = ({1'b0, in_index} < SIZE_W'(CHARSET_DEPTH));
                        end
                        OP_SEED: begin
                            num_next   = in_pos;
                            idx_next   = '0;
                            ovf_next   = 1'b0;
                            state_next = ST_SEED_KICK;
                        end
                        OP_ADVANCE: begin
                            idx_next   = '0;
                            ovf_next   = 1'b0;
                            state_next = ST_ADV;
                        end
                        default: begin
                            // unused code, no effect
                        end
                    endcase
                end
            end

            ST_SEED_KICK: begin
                div_start  = 1'b1;
                state_next = ST_SEED_WAIT;
            end

            ST_SEED_WAIT: begin
                if (div_done) begin
                    dig_we    = 1'b1;
                    dig_wdata = div_rem;
                    if (div_quot == '0) begin
                        len_next   = idx_inc[CNT_W-1:0];
                        idx_next   = '0;
                        state_next = ST_EMIT;
                    end else if (idx_inc >= (CNT_W+1)'(MAX_KEY_LEN)) begin
                        // more digits than fit: keep the low ones
                        ovf_next   = 1'b1;
                        len_next   = CNT_W'(MAX_KEY_LEN);
                        idx_next   = '0;
                        state_next = ST_EMIT;
                    end else begin
                        idx_next   = idx_inc[CNT_W-1:0];
                        num_next   = div_quot;
                        state_next = ST_SEED_KICK;
                    end
                end
            end

            ST_ADV: begin
                dig_we = 1'b1;
                if ({1'b0, cur_digit} >= last_digit) begin
                    // wrap this place and carry
                    dig_wdata = '0;
                    if (idx_inc >= {1'b0, len_reg}) begin
                        if (len_reg < CNT_W'(MAX_KEY_LEN)) begin
                            idx_next   = idx_inc[CNT_W-1:0];
                            state_next = ST_ADV_GROW;
                        end else begin
                            ovf_next   = 1'b1;
                            idx_next   = '0;
                            state_next = ST_EMIT;
                        end
                    end else begin
                        idx_next = idx_inc[CNT_W-1:0];
                    end
                end else begin
                    dig_wdata  = cur_digit + 1'b1;
                    idx_next   = '0;
                    state_next = ST_EMIT;
                end
            end

            ST_ADV_GROW: begin
                // new most significant place
                dig_we     = 1'b1;
                dig_wdata  = '0;
                len_next   = idx_inc[CNT_W-1:0];
                idx_next   = '0;
                state_next = ST_EMIT;
            end

            ST_EMIT: begin
                rd_issue = (idx_reg < len_reg) && (!rd_pend_reg || load_out);
                if (rd_issue) begin
                    idx_next      = idx_inc[CNT_W-1:0];
                    pend_idx_next = idx_reg;
                end
                if ((idx_reg == len_reg) && !rd_pend_reg) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // read in flight and output register
    always_comb begin
        pend_inc     = {1'b0, pend_idx_reg} + {{CNT_W{1'b0}}, 1'b1};
        pend_pos_ext = {{CHARPOS_W{1'b0}}, pend_idx_reg};
        if (rd_issue) begin
            rd_pend_next = 1'b1;
        end else if (load_out) begin
            rd_pend_next = 1'b0;
        end else begin
            rd_pend_next = rd_pend_reg;
        end

        out_char_next  = out_char_reg;
        out_pos_next   = out_pos_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
            out_char_next  = ram_rdata;
            out_pos_next   = pend_pos_ext[CHARPOS_W-1:0];
            out_last_next  = (pend_inc == {1'b0, len_reg});
            out_ovf_next   = ovf_reg;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            size_reg      <= CHARSET_SIZE_RST;
            idx_reg       <= '0;
            len_reg       <= CNT_W'(1);
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            ovf_reg       <= 1'b0;
            for (int i = 0; i < MAX_KEY_LEN; i++) begin
                key_digits_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            len_reg       <= len_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            ovf_reg       <= ovf_next;
            if (cfg_we) begin
                size_reg <= cfg_wdata;
            end
            if (dig_we) begin
                key_digits_reg[idx_reg[IDX_W-1:0]] <= dig_wdata;
            end
        end
        num_reg      <= num_next;
        pend_idx_reg <= pend_idx_next;
        out_char_reg <= out_char_next;
        out_pos_reg  <= out_pos_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    // result channel
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - CHAR_W - CHARPOS_W){1'b0}}, out_pos_reg, out_char_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/ckey_checker.sv
// port-level checks for the charset key enumerator, bound to the top level
// depends on ckey_pkg for operation codes
`default_nettype none

module ckey_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [ckey_pkg::OP_W-1:0]     s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [ckey_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic                          m_tlast,
    input wire logic                          m_tuser
);
    import ckey_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tlast) && $stable(m_tuser))
        else $error("result changed while stalled");

    // seed and advance occupy the block
    a_busy_after_key_op: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OP_SEED || s_tuser == OP_ADVANCE)
            |=> !s_tready)
        else $error("ready after seed or advance transfer");

    // a load keeps the block free
    a_load_single_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == OP_LOAD |=> s_tready)
        else $error("load held the input side");

    // key still being emitted while a non-final char waits
    a_no_accept_mid_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready in the middle of a key");

endmodule

bind charset_key_enumerator_unit ckey_checker u_ckey_checker (.*);

`default_nettype wire
